@@ rtl/lru_key_value_cache_assert.svh @@
// Assertion macros used by the checker file of the key-value cache.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");

`endif

@@ rtl/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned FieldW = 32;
  localparam int unsigned CapW   = 4;

  localparam logic [CapW-1:0] CapReset = 4'd8;

  typedef enum logic [CmdW-1:0] {
    CMD_PUT      = 2'd0,
    CMD_GET      = 2'd1,
    CMD_CONTAINS = 2'd2
  } lkvc_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } lkvc_state_e;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [FieldW-1:0] lookup_key;
    logic signed [FieldW-1:0] store_value;
  } lkvc_req_t;

  typedef struct packed {
    logic                     found;
    logic signed [FieldW-1:0] read_value;
  } lkvc_rsp_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement. Each request is a
// put, a get or a contains query (the unused command code acts as a contains query), and each
// gives exactly one response. Keys and values live in small memories that are read one entry
// at a time: a single comparator walks all ENTRIES entries, each with a memory read and then a
// key and recency compare, after which a decide step picks the action, an update step updates
// the recency ranks and writes the memories, and a done step loads the response into the
// output register. in_stall_o is high through all of these steps, whenever the block is not
// idle. The done step stretches while an earlier response still waits in the output register
// under out_stall_i; a new request can be taken while the previous response still waits. The
// capacity register resets to 8, its effective value is clamped to the range 1 to ENTRIES, and
// the register is always ready for a write. Lowering it below the current occupancy evicts
// nothing at once; later puts of new keys then replace the least recent entry.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lkvc_req_t       in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lkvc_rsp_t       out_rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned OccW  = $clog2(ENTRIES + 1);

  lkvc_state_e state_q, state_d;

  logic [IdxW-1:0]       idx_q, idx_d;
  logic [CmdW-1:0]       cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] rdata_q, rdata_d;

  logic                  hit_found_q, hit_found_d;
  logic [IdxW-1:0]       hit_idx_q, hit_idx_d;
  logic                  lru_found_q, lru_found_d;
  logic [IdxW-1:0]       lru_idx_q, lru_idx_d;
  logic [RankW-1:0]      lru_rank_q, lru_rank_d;
  logic                  free_found_q, free_found_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;

  logic                  touch_q, touch_d;
  logic                  write_q, write_d;
  logic                  insert_q, insert_d;
  logic [IdxW-1:0]       target_q, target_d;
  logic [RankW:0]        thr_q, thr_d;

  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [RankW-1:0]      rank_q [ENTRIES];
  logic [RankW-1:0]      rank_d [ENTRIES];
  logic [OccW-1:0]       occ_q, occ_d;
  logic [CapW-1:0]       cap_q, cap_d;

  logic                  out_valid_q, out_valid_d;
  lkvc_rsp_t             out_rsp_q, out_rsp_d;

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic                  mem_we;

  logic [63:0]           key_wide;
  logic [63:0]           val_wide;
  logic [63:0]           rdata_wide;
  logic [7:0]            cap_eff;
  logic                  is_full;

  assign key_wide   = {32'b0, in_req_i.lookup_key};
  assign val_wide   = {32'b0, in_req_i.store_value};
  assign rdata_wide = 64'(rdata_q);

  assign cap_eff = (cap_q == '0) ? 8'd1 :
                   ((8'(cap_q) > 8'(ENTRIES)) ? 8'(ENTRIES) : 8'(cap_q));
  assign is_full = (8'(occ_q) >= cap_eff);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign cfg_ready_o = 1'b1;
  assign mem_we      = (state_q == ST_UPDATE) && write_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[target_q] <= key_q;
      val_mem[target_q] <= val_q;
    end
    rd_key_q <= key_mem[idx_q];
    rd_val_q <= val_mem[idx_q];
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    rdata_d      = rdata_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    lru_found_d  = lru_found_q;
    lru_idx_d    = lru_idx_q;
    lru_rank_d   = lru_rank_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    touch_d      = touch_q;
    write_d      = write_q;
    insert_d     = insert_q;
    target_d     = target_q;
    thr_d        = thr_q;
    valid_d      = valid_q;
    rank_d       = rank_q;
    occ_d        = occ_q;
    cap_d        = cap_q;
    out_valid_d  = out_valid_q;
    out_rsp_d    = out_rsp_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cap_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = in_req_i.cmd;
          key_d        = key_wide[KEY_BITS-1:0];
          val_d        = val_wide[VALUE_BITS-1:0];
          idx_d        = '0;
          hit_found_d  = 1'b0;
          lru_found_d  = 1'b0;
          free_found_d = 1'b0;
          touch_d      = 1'b0;
          write_d      = 1'b0;
          insert_d     = 1'b0;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (valid_q[idx_q]) begin
          if (!hit_found_q && (rd_key_q == key_q)) begin
            hit_found_d = 1'b1;
            hit_idx_d   = idx_q;
            rdata_d     = rd_val_q;
          end
          if (!lru_found_q || (rank_q[idx_q] > lru_rank_q)) begin
            lru_found_d = 1'b1;
            lru_idx_d   = idx_q;
            lru_rank_d  = rank_q[idx_q];
          end
        end else if (!free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (idx_q == IdxW'(ENTRIES - 1)) begin
          state_d = ST_DECIDE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_DECIDE: begin
        if (cmd_q == CMD_PUT) begin
          if (hit_found_q) begin
            target_d = hit_idx_q;
            thr_d    = {1'b0, rank_q[hit_idx_q]};
            touch_d  = 1'b1;
            write_d  = 1'b1;
          end else if (is_full) begin
            target_d = lru_idx_q;
            thr_d    = {1'b0, lru_rank_q};
            touch_d  = lru_found_q;
            write_d  = lru_found_q;
          end else if (free_found_q) begin
            target_d = free_idx_q;
            thr_d    = '1;
            touch_d  = 1'b1;
            write_d  = 1'b1;
            insert_d = 1'b1;
          end
        end else if ((cmd_q == CMD_GET) && hit_found_q) begin
          target_d = hit_idx_q;
          thr_d    = {1'b0, rank_q[hit_idx_q]};
          touch_d  = 1'b1;
        end
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (touch_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && (IdxW'(i) != target_q) && ({1'b0, rank_q[i]} < thr_q)) begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
          rank_d[target_q]  = '0;
          valid_d[target_q] = 1'b1;
        end
        if (insert_q) begin
          occ_d = occ_q + 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_rsp_d.found      = hit_found_q;
          out_rsp_d.read_value = ((cmd_q == CMD_GET) && hit_found_q) ?
                                 rdata_wide[FieldW-1:0] : '0;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      hit_found_q  <= 1'b0;
      lru_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      touch_q      <= 1'b0;
      write_q      <= 1'b0;
      insert_q     <= 1'b0;
      valid_q      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
      occ_q        <= '0;
      cap_q        <= CapReset;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      hit_found_q  <= hit_found_d;
      lru_found_q  <= lru_found_d;
      free_found_q <= free_found_d;
      touch_q      <= touch_d;
      write_q      <= write_d;
      insert_q     <= insert_d;
      valid_q      <= valid_d;
      rank_q       <= rank_d;
      occ_q        <= occ_d;
      cap_q        <= cap_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    rdata_q    <= rdata_d;
    hit_idx_q  <= hit_idx_d;
    lru_idx_q  <= lru_idx_d;
    lru_rank_q <= lru_rank_d;
    free_idx_q <= free_idx_d;
    target_q   <= target_d;
    thr_q      <= thr_d;
    out_rsp_q  <= out_rsp_d;
  end

endmodule

@@ rtl/lkvc_checker.sv @@
`include "lru_key_value_cache_assert.svh"

module lkvc_checker
  import lkvc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input lkvc_rsp_t out_rsp_o
);

  `LKVC_ASSERT_NEXT(held_rsp_a, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))
  `LKVC_ASSERT_SAME(miss_zero_a, out_valid_o && !out_rsp_o.found, out_rsp_o.read_value == '0)
  `LKVC_ASSERT_NEXT(busy_after_req_a, in_valid_i && !in_stall_o, in_stall_o)
  `LKVC_ASSERT_SAME(rsp_from_work_a, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
